### hdl/mono_to_stereo_pan_gate_mixer_core_defines.svh
// assertion macros used by the checker
`ifndef MONO_TO_STEREO_PAN_GATE_MIXER_CORE_DEFINES_SVH
`define MONO_TO_STEREO_PAN_GATE_MIXER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MPGM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MPGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mpgm_pkg.sv
package mpgm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int COUNT_W    = 24;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 48;
  localparam int STEP_CNT_W = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0]  GAIN_UNITY = 16'd4096;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 24'd256;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFFFFFF;

  localparam logic [SAMPLE_W-1:0] OUT_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] OUT_MIN = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_PHASE_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_LOADB,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
  } mul_ctl_t;

endpackage

### hdl/mpgm_gate.sv
module mpgm_gate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [mpgm_pkg::COUNT_W-1:0]  half_period,
  input  logic [mpgm_pkg::GAIN_W-1:0]   off_phase_gain,
  output logic [mpgm_pkg::GAIN_W-1:0]   gate
);

  logic [mpgm_pkg::COUNT_W-1:0] phase_count;
  logic [mpgm_pkg::COUNT_W-1:0] phase_count_next;
  logic                         on_phase;
  logic                         on_phase_next;
  logic                         pulsing;
  logic [mpgm_pkg::COUNT_W:0]   count_inc;

  assign pulsing   = (half_period != '0);
  assign count_inc = {1'b0, phase_count} + {1'b0, mpgm_pkg::COUNT_ONE};
  assign gate      = (pulsing && !on_phase) ? off_phase_gain : mpgm_pkg::GAIN_UNITY;

  always_comb begin
    phase_count_next = phase_count;
    on_phase_next    = on_phase;
    if (pulsing) begin
      if (phase_count >= half_period) begin
        phase_count_next = phase_count - half_period;
        on_phase_next    = !on_phase;
      end else if (count_inc[mpgm_pkg::COUNT_W]) begin
        // counter pinned at its top value
        phase_count_next = mpgm_pkg::COUNT_MAX;
      end else begin
        phase_count_next = count_inc[mpgm_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      on_phase    <= 1'b1;
    end else if (advance) begin
      phase_count <= phase_count_next;
      on_phase    <= on_phase_next;
    end
  end

endmodule

### hdl/mpgm_chan.sv
module mpgm_chan (
  input  logic                           clk,
  input  mpgm_pkg::mul_ctl_t             ctl,
  input  logic [mpgm_pkg::GAIN_W-1:0]    gain,
  input  logic [mpgm_pkg::GAIN_W-1:0]    gate,
  input  logic [mpgm_pkg::SAMPLE_W-1:0]  mag,
  input  logic                           neg,
  output logic [mpgm_pkg::SAMPLE_W-1:0]  result
);

  logic [mpgm_pkg::ACC_W-1:0]    acc;
  logic [mpgm_pkg::PROD_W-1:0]   mcand;
  logic [mpgm_pkg::SAMPLE_W-1:0] mplier;
  logic [mpgm_pkg::PROD_W:0]     sum;
  logic [mpgm_pkg::COUNT_W-1:0]  q;

  // shift-add over one multiplier bit per cycle; adds land in the top bits
  assign sum = {1'b0, acc[mpgm_pkg::ACC_W-1:mpgm_pkg::SAMPLE_W]}
             + (mplier[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      acc    <= '0;
      mcand  <= {{(mpgm_pkg::PROD_W-mpgm_pkg::GAIN_W){1'b0}}, gain};
      mplier <= gate;
    end else if (ctl.load_b) begin
      // gain * gate sits in the low bits after the first pass
      acc    <= '0;
      mcand  <= acc[mpgm_pkg::PROD_W-1:0];
      mplier <= mag;
    end else if (ctl.step) begin
      acc    <= {sum, acc[mpgm_pkg::SAMPLE_W-1:1]};
      mplier <= {1'b0, mplier[mpgm_pkg::SAMPLE_W-1:1]};
    end
  end

  assign q = acc[mpgm_pkg::ACC_W-1:mpgm_pkg::ACC_W-mpgm_pkg::COUNT_W];

  always_comb begin
    if (neg) begin
      if (q > {8'd0, mpgm_pkg::OUT_MIN}) begin
        result = mpgm_pkg::OUT_MIN;
      end else begin
        result = ~q[mpgm_pkg::SAMPLE_W-1:0] + 16'd1;
      end
    end else begin
      if (q > {8'd0, mpgm_pkg::OUT_MAX}) begin
        result = mpgm_pkg::OUT_MAX;
      end else begin
        result = q[mpgm_pkg::SAMPLE_W-1:0];
      end
    end
  end

endmodule

### hdl/mono_to_stereo_pan_gate_mixer_core.sv
// mono to stereo pan mixer with pulse gate. each mono sample (s_tdata, signed 16 bit)
// gives one stereo frame: left and right are sample * channel gain * gate / 2^24,
// truncated toward zero and saturated to 16 bits; s_tlast passes to m_tlast. gains
// are unsigned q4.12, half_period is q16.8 and zero turns the gate off. each channel
// has a bit-serial shift-add multiplier: the accept cycle loads both multipliers,
// ST_GAIN forms gain * gate, ST_LOADB reloads, ST_SCALE scales the sample
// magnitude and ST_DONE moves the result into the output register; only then is
// a new sample taken. the move waits while the previous frame is still unread.
// a new sample is accepted while the previous frame waits on m_tready. config
// writes (cfg_index 0..3: left, right, off-phase gain, half period) are always
// taken and belong in idle time only; other indexes are ignored.
module mono_to_stereo_pan_gate_mixer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,   // [15:0] sample_in
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // [15:0] left_out, [31:16] right_out
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpgm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mpgm_pkg::state_t state;
  mpgm_pkg::state_t state_next;
  mpgm_pkg::mul_ctl_t mul_ctl;

  logic [mpgm_pkg::GAIN_W-1:0]     left_gain;
  logic [mpgm_pkg::GAIN_W-1:0]     right_gain;
  logic [mpgm_pkg::GAIN_W-1:0]     off_phase_gain;
  logic [mpgm_pkg::COUNT_W-1:0]    half_period;
  logic [mpgm_pkg::GAIN_W-1:0]     gate;
  logic [mpgm_pkg::STEP_CNT_W-1:0] step_cnt;
  logic [mpgm_pkg::SAMPLE_W-1:0]   sample;
  logic [mpgm_pkg::SAMPLE_W-1:0]   mag;
  logic                            neg;
  logic                            last;
  logic [mpgm_pkg::SAMPLE_W-1:0]   left_res;
  logic [mpgm_pkg::SAMPLE_W-1:0]   right_res;
  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic                            step_last;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign step_last = (step_cnt == '1);
  assign neg       = sample[mpgm_pkg::SAMPLE_W-1];
  assign mag       = neg ? (~sample + 16'd1) : sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_gain      <= mpgm_pkg::GAIN_UNITY;
      right_gain     <= mpgm_pkg::GAIN_UNITY;
      off_phase_gain <= '0;
      half_period    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpgm_pkg::REG_LEFT_GAIN:      left_gain      <= cfg_data[mpgm_pkg::GAIN_W-1:0];
        mpgm_pkg::REG_RIGHT_GAIN:     right_gain     <= cfg_data[mpgm_pkg::GAIN_W-1:0];
        mpgm_pkg::REG_OFF_PHASE_GAIN: off_phase_gain <= cfg_data[mpgm_pkg::GAIN_W-1:0];
        mpgm_pkg::REG_HALF_PERIOD:    half_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mpgm_pkg::ST_IDLE:  if (s_tvalid) state_next = mpgm_pkg::ST_GAIN;
      mpgm_pkg::ST_GAIN:  if (step_last) state_next = mpgm_pkg::ST_LOADB;
      mpgm_pkg::ST_LOADB: state_next = mpgm_pkg::ST_SCALE;
      mpgm_pkg::ST_SCALE: if (step_last) state_next = mpgm_pkg::ST_DONE;
      mpgm_pkg::ST_DONE:  if (out_free) state_next = mpgm_pkg::ST_IDLE;
      default:            state_next = mpgm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready       = 1'b0;
    mul_ctl.load_a = 1'b0;
    mul_ctl.load_b = 1'b0;
    mul_ctl.step   = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      mpgm_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        mul_ctl.load_a = s_tvalid;
      end
      mpgm_pkg::ST_GAIN:  mul_ctl.step   = 1'b1;
      mpgm_pkg::ST_LOADB: mul_ctl.load_b = 1'b1;
      mpgm_pkg::ST_SCALE: mul_ctl.step   = 1'b1;
      mpgm_pkg::ST_DONE:  out_load       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpgm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || mul_ctl.load_a || mul_ctl.load_b) begin
      step_cnt <= '0;
    end else if (mul_ctl.step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= s_tdata;
      last   <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {right_res, left_res};
      m_tlast <= last;
    end
  end

  mpgm_gate u_gate (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .half_period    (half_period),
    .off_phase_gain (off_phase_gain),
    .gate           (gate)
  );

  mpgm_chan u_left (
    .clk    (clk),
    .ctl    (mul_ctl),
    .gain   (left_gain),
    .gate   (gate),
    .mag    (mag),
    .neg    (neg),
    .result (left_res)
  );

  mpgm_chan u_right (
    .clk    (clk),
    .ctl    (mul_ctl),
    .gain   (right_gain),
    .gate   (gate),
    .mag    (mag),
    .neg    (neg),
    .result (right_res)
  );

endmodule

### hdl/mpgm_checker.sv
`include "mono_to_stereo_pan_gate_mixer_core_defines.svh"

module mpgm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled frame holds
  `MPGM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output frame changed under stall")

  // one sample at a time: busy right after an accept
  `MPGM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")

  // a new frame never follows directly from a sample accepted in the cycle before
  `MPGM_ASSERT_NOW(a_no_instant_frame, $rose(m_tvalid), !$past(s_tvalid && s_tready), "frame appeared too early")

  // config writes never stall
  `MPGM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind mono_to_stereo_pan_gate_mixer_core mpgm_checker u_mpgm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
